// File: sv/mbt_pkg.sv
// ============================================================================
// mbt_pkg: shared types and constants of the multiset bag table
// operation codes, item layouts and the flags passed along the cell chain
// ============================================================================
package mbt_pkg;

    // default sizes handed to the top level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // input item layout
    localparam int FUNC_W     = 2;
    localparam int IN_VALUE_W = 32;
    localparam int S_TDATA_W  = 40;

    // result item layout
    localparam int CNT_OUT_W  = 7;
    localparam int M_TDATA_W  = 16;

    // widest value the sign extension covers
    localparam int EXT_W      = 64;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // scan token and first-match flag, handed from cell to cell
    typedef struct packed {
        logic tok;
        logic found;
    } scan_flags_t;

endpackage

// File: sv/mbt_cell.sv
// ============================================================================
// mbt_cell: one slot of the bag
// holds one entry, compares it when the scan token passes, counts matches,
// takes a new value on add and its right neighbour's entry on remove
// ============================================================================
module mbt_cell
    import mbt_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  op_t                    op,
    input  logic [VALUE_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]       count,
    input  scan_flags_t            flags_in,
    input  logic [CNT_W-1:0]       cnt_in,
    input  logic [VALUE_WIDTH-1:0] nb_entry,
    output scan_flags_t            flags_out,
    output logic [CNT_W-1:0]       cnt_out,
    output logic [VALUE_WIDTH-1:0] entry
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    scan_flags_t            flags_reg;
    scan_flags_t            flags_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   occupied;
    logic                   match;

    always_comb
    begin
        occupied         = MY_IDX < count;
        match            = flags_in.tok && occupied && (entry_reg == key);
        flags_next.tok   = flags_in.tok;
        flags_next.found = flags_in.found | match;
        cnt_next         = cnt_in + CNT_W'(match);
        entry_next       = entry_reg;
        if (flags_in.tok && (op == OP_ADD) && (MY_IDX == count))
        begin
            // first free slot takes the new value
            entry_next = key;
        end
        else if (flags_in.tok && (op == OP_REMOVE) && (flags_in.found || match))
        begin
            // close the gap left by the removed copy
            entry_next = nb_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        entry_reg <= entry_next;
    end

    assign flags_out = flags_reg;
    assign cnt_out   = cnt_reg;
    assign entry     = entry_reg;

endmodule

// File: sv/multiset_bag_table.sv
// ============================================================================
// multiset_bag_table: fixed-capacity multiset of signed values
// a row of slot cells scanned by a token that counts copies of the key
// ============================================================================
//
// channel  dir  handshake         payload
// -------  ---  ----------------  -------------------------------------------
// s_*      in   s_tvalid/s_tready s_tdata: func[1:0], value[33:2], zero pad
// m_*      out  m_tvalid/m_tready m_tdata: ok[0], copies[7:1], size[14:8],
//                                          empty_res[15]
//
// - after acceptance the scan token walks the cell chain one slot per cycle,
//   and the result is offered once the token has left the last slot
// - one item is in work at a time; s_tready is high only while idle, and the
//   next item is taken as soon as the result has moved to the output register
// - a stalled result holds the block in its result state until the output
//   register frees up
// - reset empties the bag at once: slot contents are left as they are and
//   only slots below the fill count are ever compared
//
module multiset_bag_table
    import mbt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func[1:0], value[33:2], pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // ok, copies[7], size[7], empty_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    // control state
    state_t                 state_reg;
    state_t                 state_next;
    logic                   start_reg;
    logic                   start_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;

    // request and result payload
    op_t                    op_reg;
    op_t                    op_next;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] key_next;
    logic [M_TDATA_W-1:0]   res_reg;
    logic [M_TDATA_W-1:0]   res_next;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TDATA_W-1:0]   m_data_next;

    // input decode
    logic [FUNC_W-1:0]      in_func;
    logic [IN_VALUE_W-1:0]  in_value;
    logic [EXT_W-1:0]       in_ext;
    logic [VALUE_WIDTH-1:0] key_in;

    // cell chain
    scan_flags_t            flags [CAPACITY+1];
    logic [CNT_W-1:0]       cnt   [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] entry [CAPACITY];
    logic [VALUE_WIDTH-1:0] nb    [CAPACITY];

    // result build
    logic [CNT_W-1:0]       hit_cnt;
    logic                   found;
    logic                   has_room;
    logic                   res_ok;
    logic [CNT_W-1:0]       res_copies;
    logic [CNT_W-1:0]       res_size;
    logic [M_TDATA_W-1:0]   res_word;

    // value is sign extended, then kept in its low VALUE_WIDTH bits
    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_value = s_tdata[FUNC_W +: IN_VALUE_W];
    assign in_ext   = {{(EXT_W - IN_VALUE_W){in_value[IN_VALUE_W-1]}}, in_value};
    assign key_in   = in_ext[VALUE_WIDTH-1:0];

    // token enters slot 0 the cycle after acceptance
    assign flags[0] = '{tok: start_reg, found: 1'b0};
    assign cnt[0]   = '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == CAPACITY - 1)
            begin : g_tail
                // last slot has no right neighbour; what it takes is past the fill
                assign nb[i] = entry[i];
            end
            else
            begin : g_body
                assign nb[i] = entry[i+1];
            end

            mbt_cell #(
                .IDX         (i),
                .CAPACITY    (CAPACITY),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op_reg),
                .key       (key_reg),
                .count     (count_reg),
                .flags_in  (flags[i]),
                .cnt_in    (cnt[i]),
                .nb_entry  (nb[i]),
                .flags_out (flags[i+1]),
                .cnt_out   (cnt[i+1]),
                .entry     (entry[i])
            );
        end
    endgenerate

    // result once the token leaves the last slot; matches are counted on
    // the contents before this item's change
    always_comb
    begin
        hit_cnt  = cnt[CAPACITY];
        found    = flags[CAPACITY].found;
        has_room = count_reg != CAP_CNT;
        case (op_reg)
            OP_ADD:
            begin
                res_ok     = has_room;
                res_copies = hit_cnt + CNT_W'(has_room);
                res_size   = count_reg + CNT_W'(has_room);
            end
            OP_REMOVE:
            begin
                res_ok     = found;
                res_copies = hit_cnt - CNT_W'(found);
                res_size   = count_reg - CNT_W'(found);
            end
            OP_CLEAR:
            begin
                res_ok     = 1'b1;
                res_copies = '0;
                res_size   = '0;
            end
            default:
            begin
                // query leaves the bag as it is
                res_ok     = hit_cnt != '0;
                res_copies = hit_cnt;
                res_size   = count_reg;
            end
        endcase
        res_word = {(res_size == '0), CNT_OUT_W'(res_size), CNT_OUT_W'(res_copies), res_ok};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        start_next   = 1'b0;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(in_func);
                    key_next   = key_in;
                    start_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (flags[CAPACITY].tok)
                begin
                    count_next = res_size;
                    res_next   = res_word;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // output register free or emptied in this cycle
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: sv/mbt_checker.sv
// ============================================================================
// mbt_checker: port-level checks of the multiset bag table
// watches both item channels and the result fields over time
// ============================================================================
module mbt_checker
    import mbt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // counts wrap in the result fields past this size
    localparam bit WIDE = CAPACITY > 127;

    // one item at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    // a fresh result leaves the block ready for the next item
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result offered but input not reopened");

    // empty flag agrees with the size field
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (WIDE || (m_tdata[15] == (m_tdata[14:8] == 7'd0))))
        else $error("empty flag disagrees with size");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind multiset_bag_table mbt_checker #(.CAPACITY(CAPACITY)) u_mbt_checker (.*);
